// File: rtl/band_level_averager_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the band level averager
// Immediate-cycle and next-cycle implication checks on the top level clock.
// ---------------------------------------------------------------------------
`ifndef BAND_LEVEL_AVERAGER_TOP_ASSERT_SVH
`define BAND_LEVEL_AVERAGER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define BLA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BLA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BLA_ASSERT_IMP(lbl, ante, cons, msg)
`define BLA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/bla_pkg.sv
// ---------------------------------------------------------------------------
// Band level averager package
// Widths, limits, level threshold table and controller/datapath interface.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bla_pkg;

  localparam int NUM_BANDS   = 7;
  localparam int BAND_W      = 3;
  localparam int SAMPLE_W    = 16;
  localparam int LEVEL_W     = 8;
  localparam int LEVEL_MAX   = 250;
  localparam int TOTAL_W     = 18;
  localparam int COUNT_W     = 10;
  localparam int MAX_SAMPLES = 1023;
  localparam int THR_RESET   = 60;
  localparam int ANCHOR_CODE = 55;
  localparam int STEP_W      = 5;
  localparam int SRCH_STEPS  = LEVEL_W;
  localparam int DIV_STEPS   = TOTAL_W;
  localparam int LED_BAND    = 3;
  localparam int LAST_BAND   = NUM_BANDS - 1;

  localparam logic [63:0] QUP = 64'd49733377;
  localparam logic [63:0] QDN = 64'd49164084;

  typedef logic [SAMPLE_W-1:0] thr_tab_t [256];

  // Rising thresholds: T[k] is the smallest reading with level code k
  function automatic thr_tab_t build_thr();
    thr_tab_t    t;
    logic [63:0] v;
    logic [63:0] p;
    for (int k = 0; k < 256; k++) begin
      t[k] = '1;
    end
    t[0] = '0;
    v = 64'd875 << 23;
    t[ANCHOR_CODE] = SAMPLE_W'((v + 64'hFFFFFF) >> 24);
    for (int k = ANCHOR_CODE + 1; k <= LEVEL_MAX; k++) begin
      p = v * QUP;
      v = v + (p >> 32);
      t[k] = SAMPLE_W'((v + 64'hFFFFFF) >> 24);
    end
    v = 64'd875 << 23;
    for (int k = ANCHOR_CODE - 1; k >= 1; k--) begin
      p = v * QDN;
      v = v - (p >> 32);
      t[k] = SAMPLE_W'((v + 64'hFFFFFF) >> 24);
    end
    return t;
  endfunction

  localparam thr_tab_t THR = build_thr();

  typedef struct packed {
    logic              load;
    logic              srch;
    logic [2:0]        srch_bit;
    logic              accum;
    logic              div_load;
    logic              div_step;
    logic              emit;
    logic              tick;
    logic [BAND_W-1:0] band;
    logic              clr_band3;
  } cmd_t;

  typedef struct packed {
    logic last_band;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/bla_ctrl.sv
// ---------------------------------------------------------------------------
// Band level averager controller
// Sequences level search, accumulation, per-band division and result issue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bla_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  input  wire              in_mode,
  output logic             in_ready,
  output bla_pkg::cmd_t    cmd,
  input  bla_pkg::status_t status
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_ACCUM = 3'd2;
  localparam logic [2:0] S_DLOAD = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]                  state, state_next;
  logic [bla_pkg::STEP_W-1:0]  step, step_next;
  logic [bla_pkg::BAND_W-1:0]  band, band_next;
  logic                        tick, tick_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      band  <= '0;
      tick  <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      band  <= band_next;
      tick  <= tick_next;
    end
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    band_next    = band;
    tick_next    = tick;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.srch_bit = step[2:0];
    cmd.band     = band;
    cmd.tick     = tick;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          tick_next = in_mode;
          band_next = '0;
          if (in_mode) begin
            state_next = S_DLOAD;
          end else begin
            step_next  = bla_pkg::STEP_W'(bla_pkg::SRCH_STEPS - 1);
            state_next = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        cmd.srch  = 1'b1;
        step_next = step - 1'b1;
        if (step == '0) begin
          state_next = S_ACCUM;
        end
      end
      S_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = status.last_band ? S_EMIT : S_IDLE;
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        step_next    = bla_pkg::STEP_W'(bla_pkg::DIV_STEPS - 1);
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step - 1'b1;
        if (step == '0) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (!tick) begin
            state_next = S_IDLE;
          end else if (band == bla_pkg::BAND_W'(bla_pkg::LAST_BAND)) begin
            cmd.clr_band3 = 1'b1;
            state_next    = S_IDLE;
          end else begin
            band_next  = band + 1'b1;
            state_next = S_DLOAD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/bla_dp.sv
// ---------------------------------------------------------------------------
// Band level averager datapath
// Level search, per-band totals and counts, serial divider, result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bla_dp (
  input  wire                            clk,
  input  wire                            rst,
  input  wire [bla_pkg::SAMPLE_W-1:0]    in_sample,
  input  wire                            cfg_wr_en,
  input  wire [bla_pkg::LEVEL_W-1:0]     cfg_wr_data,
  input  bla_pkg::cmd_t                  cmd,
  output bla_pkg::status_t               status,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic                           out_kind,
  output logic [bla_pkg::BAND_W-1:0]     out_band,
  output logic [bla_pkg::LEVEL_W-1:0]    out_level,
  output logic                           out_ind,
  output logic                           out_last
);

  logic [bla_pkg::LEVEL_W-1:0]  thr;
  logic [bla_pkg::SAMPLE_W-1:0] sample;
  logic [bla_pkg::LEVEL_W-1:0]  code;
  logic [bla_pkg::BAND_W-1:0]   band_index;
  logic [bla_pkg::LEVEL_W-1:0]  band3_level;
  logic [bla_pkg::TOTAL_W-1:0]  totals [bla_pkg::NUM_BANDS];
  logic [bla_pkg::COUNT_W-1:0]  counts [bla_pkg::NUM_BANDS];
  logic [bla_pkg::TOTAL_W-1:0]  dvd;
  logic [bla_pkg::COUNT_W-1:0]  dvs;
  logic [bla_pkg::COUNT_W-1:0]  rem;

  logic [bla_pkg::BAND_W-1:0]   cur;
  logic [bla_pkg::LEVEL_W-1:0]  cand;
  logic                         cand_hit;
  logic [bla_pkg::TOTAL_W:0]    sum;
  logic [bla_pkg::COUNT_W:0]    rem_sh;
  logic                         rem_ge;

  always_comb begin
    cur = (band_index >= bla_pkg::BAND_W'(bla_pkg::LAST_BAND))
        ? bla_pkg::BAND_W'(bla_pkg::LAST_BAND) : band_index;
    status.last_band = (cur == bla_pkg::BAND_W'(bla_pkg::LAST_BAND));
    status.out_free  = !out_valid || out_ready;
    cand     = code | (bla_pkg::LEVEL_W'(1) << cmd.srch_bit);
    cand_hit = (cand <= bla_pkg::LEVEL_W'(bla_pkg::LEVEL_MAX)) && (sample >= bla_pkg::THR[cand]);
    sum      = {1'b0, totals[cur]} + (bla_pkg::TOTAL_W + 1)'(code);
    rem_sh   = {rem, dvd[bla_pkg::TOTAL_W-1]};
    rem_ge   = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= bla_pkg::LEVEL_W'(bla_pkg::THR_RESET);
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  // search: one threshold compare per bit, most significant first
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample <= in_sample;
      code   <= '0;
    end else if (cmd.srch && cand_hit) begin
      code <= cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      band_index  <= '0;
      band3_level <= '0;
      for (int j = 0; j < bla_pkg::NUM_BANDS; j++) begin
        totals[j] <= '0;
        counts[j] <= '0;
      end
    end else begin
      if (cmd.accum) begin
        if (counts[cur] < bla_pkg::COUNT_W'(bla_pkg::MAX_SAMPLES)) begin
          totals[cur] <= sum[bla_pkg::TOTAL_W] ? '1 : sum[bla_pkg::TOTAL_W-1:0];
          counts[cur] <= counts[cur] + 1'b1;
        end
        if (cur == bla_pkg::BAND_W'(bla_pkg::LED_BAND)) begin
          band3_level <= code;
        end
        band_index <= status.last_band ? '0 : cur + 1'b1;
      end
      if (cmd.emit && cmd.tick) begin
        totals[cmd.band] <= '0;
        counts[cmd.band] <= '0;
      end
      if (cmd.clr_band3) begin
        band3_level <= '0;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dvd <= totals[cmd.band];
      dvs <= counts[cmd.band];
      rem <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[bla_pkg::TOTAL_W-2:0], rem_ge};
      rem <= rem_ge ? bla_pkg::COUNT_W'(rem_sh - {1'b0, dvs})
                    : rem_sh[bla_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.tick) begin
        out_kind  <= 1'b1;
        out_band  <= cmd.band;
        out_level <= (dvs == '0) ? '0 : dvd[bla_pkg::LEVEL_W-1:0];
        out_ind   <= 1'b0;
        out_last  <= (cmd.band == bla_pkg::BAND_W'(bla_pkg::LAST_BAND));
      end else begin
        out_kind  <= 1'b0;
        out_band  <= '0;
        out_level <= '0;
        out_ind   <= band3_level > thr;
        out_last  <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/band_level_averager_top.sv
// ---------------------------------------------------------------------------
// Band level averager
// Per-band sound level averaging for a seven-band spectrum analyser.
// ---------------------------------------------------------------------------
// Input items on s_axis: tuser = mode (0 sample, 1 tick), tdata = raw reading.
// Samples arrive in band order 0..6. Each is processed after acceptance by
// an 8-step binary search over the threshold table, then one accumulate.
// The sample for band 6 adds one indicator item on m_axis (tuser 0, tlast 1),
// and the controller returns to idle once that item is issued.
// A tick gives seven band averages (tuser 1), band 6 with tlast, one band after
// another. Each is made by a load, the restoring divider over the 18-bit total
// and an issue.
// One item is in work at a time; s_axis_tready is high only when idle.
// A single output register holds a result; when the receiver stalls the
// controller waits before loading the next one, and a new input item can be
// taken while the last result still waits.
// cfg_wr_en/cfg_wr_data write the indicator threshold; write it while idle.
// Reset (rst, synchronous) clears totals, counts, band index and band-3
// level, and sets the threshold to 60.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module band_level_averager_top (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [15:0] s_axis_tdata,   // [15:0] sample
  input  wire        s_axis_tuser,   // [0] mode
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [2:0] band, [10:3] level, [11] indicator_on
  output logic       m_axis_tuser,   // [0] kind
  output logic       m_axis_tlast,
  input  wire        cfg_wr_en,
  input  wire [7:0]  cfg_wr_data
);

  bla_pkg::cmd_t                  cmd;
  bla_pkg::status_t               status;
  logic [bla_pkg::BAND_W-1:0]     out_band;
  logic [bla_pkg::LEVEL_W-1:0]    out_level;
  logic                           out_ind;

  bla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_mode  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .status   (status)
  );

  bla_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_sample   (s_axis_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_kind    (m_axis_tuser),
    .out_band    (out_band),
    .out_level   (out_level),
    .out_ind     (out_ind),
    .out_last    (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, out_ind, out_level, out_band};

`include "band_level_averager_top_assert.svh"

`BLA_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready held after accept")
`BLA_ASSERT_IMP(a_ind_single, m_axis_tvalid && !m_axis_tuser, m_axis_tlast && (m_axis_tdata[10:0] == 11'd0), "bad indicator item")
`BLA_ASSERT_IMP(a_avg_band, m_axis_tvalid && m_axis_tuser, (m_axis_tdata[2:0] != 3'd7) && (m_axis_tlast == (m_axis_tdata[2:0] == 3'd6)), "bad average item")
`BLA_ASSERT_IMP(a_avg_no_ind, m_axis_tvalid && m_axis_tuser, !m_axis_tdata[11], "indicator set in average")

endmodule

`default_nettype wire
